@@ sv/png_chunk_deframer_unit_macros.svh @@
// Assertion macros shared by the PNG chunk deframer RTL.
// No dependencies; expects clk and arst_n to exist in the including module.
`ifndef PNG_CHUNK_DEFRAMER_UNIT_MACROS_SVH
`define PNG_CHUNK_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must never be seen.
`define PCD_ASSERT_NEVER(label, cond, msg) \
	`PCD_ASSERT_IMPLIES(label, 1'b1, !(cond), msg)

`endif

@@ sv/pcd_pkg.sv @@
// Shared types and constants of the PNG chunk deframer.
// No dependencies; used by every RTL module of the block.
package pcd_pkg;

	// Result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_SIGNATURE = 2'd0;
	localparam logic [1:0] ERR_NO_HEADER = 2'd1;
	localparam logic [1:0] ERR_COLOR     = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED = 2'd3;

	// Chunk type codes, big-endian ASCII
	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	// Last captured header payload index
	localparam logic [31:0] HDR_LAST_INDEX = 32'd12;

	// Configuration register
	localparam logic       CFG_REQ_COLOR_IDX  = 1'b0;
	localparam logic [7:0] REQ_COLOR_RESET    = 8'd6;

	// Result queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One queue entry: the results caused by one input item
	typedef struct packed {
		logic            has_data;
		logic            has_end;
		logic [7:0]      payload;
		logic [1:0]      end_kind;
		logic [1:0]      end_err;
		logic [31:0]     width;
		logic [31:0]     height;
		logic [4:0][7:0] hdr;    // bit depth, color, compression, filter, interlace
	} pcd_entry_t;

	// Queue status toward front and back
	typedef struct packed {
		logic full;
		logic empty;
	} pcd_qstat_t;

	// PNG file signature byte by position
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'd137;
			3'd1: b = 8'd80;
			3'd2: b = 8'd78;
			3'd3: b = 8'd71;
			3'd4: b = 8'd13;
			3'd5: b = 8'd10;
			3'd6: b = 8'd26;
			default: b = 8'd10;
		endcase
		return b;
	endfunction

endpackage

@@ sv/pcd_front.sv @@
// Front end of the PNG chunk deframer: byte parser and result classifier.
// Depends on pcd_pkg and png_chunk_deframer_unit_macros.svh.
`include "png_chunk_deframer_unit_macros.svh"

module pcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_first,
	input  logic               in_final,
	input  logic [7:0]         req_color,
	input  pcd_pkg::pcd_qstat_t qstat,
	output logic               push,
	output pcd_pkg::pcd_entry_t push_entry
);

	typedef enum logic [4:0] {
		PH_SIG     = 5'b00001,
		PH_LEN     = 5'b00010,
		PH_TYPE    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CRC     = 5'b10000
	} pcd_phase_t;

	pcd_phase_t      phase_q, cur_phase, nxt_phase;
	logic [31:0]     cnt_q, cur_cnt, nxt_cnt, cnt_inc;
	logic [31:0]     len_q, cur_len, nxt_len;
	logic [31:0]     type_q, cur_type, nxt_type;
	logic            sig_ok_q, cur_sig_ok, nxt_sig_ok;
	logic [31:0]     width_q, cur_width, nxt_width;
	logic [31:0]     height_q, cur_height, nxt_height;
	logic [4:0][7:0] hdr_q, cur_hdr, nxt_hdr;
	logic            seen_q, cur_seen, nxt_seen;
	logic            fin_q, cur_fin, nxt_fin;
	logic            accept;
	logic            has_data, has_end;
	logic [1:0]      end_kind, end_err;
	logic [3:0]      hdr_off;
	logic [2:0]      hdr_idx;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Start-of-file marker restarts from the reset view of the state
	always_comb begin
		cur_phase  = in_first ? PH_SIG : phase_q;
		cur_cnt    = in_first ? 32'd0 : cnt_q;
		cur_len    = in_first ? 32'd0 : len_q;
		cur_type   = in_first ? 32'd0 : type_q;
		cur_sig_ok = in_first ? 1'b1 : sig_ok_q;
		cur_width  = in_first ? 32'd0 : width_q;
		cur_height = in_first ? 32'd0 : height_q;
		cur_hdr    = in_first ? '0 : hdr_q;
		cur_seen   = in_first ? 1'b0 : seen_q;
		cur_fin    = in_first ? 1'b0 : fin_q;
	end

	assign cnt_inc = cur_cnt + 32'd1;
	assign hdr_off = cur_cnt[3:0] - 4'd8;
	assign hdr_idx = hdr_off[2:0];

	// Per-byte parser step
	always_comb begin
		nxt_phase  = cur_phase;
		nxt_cnt    = cur_cnt;
		nxt_len    = cur_len;
		nxt_type   = cur_type;
		nxt_sig_ok = cur_sig_ok;
		nxt_width  = cur_width;
		nxt_height = cur_height;
		nxt_hdr    = cur_hdr;
		nxt_seen   = cur_seen;
		nxt_fin    = cur_fin;
		has_data   = 1'b0;
		has_end    = 1'b0;
		end_kind   = pcd_pkg::KIND_ERROR;
		end_err    = pcd_pkg::ERR_SIGNATURE;
		if (!cur_fin) begin
			case (cur_phase)
				PH_SIG: begin
					if (in_byte != pcd_pkg::sig_byte(cur_cnt[2:0]))
						nxt_sig_ok = 1'b0;
					if (cur_cnt[2:0] == 3'd7) begin
						nxt_cnt = 32'd0;
						if (!nxt_sig_ok) begin
							has_end  = 1'b1;
							end_kind = pcd_pkg::KIND_ERROR;
							end_err  = pcd_pkg::ERR_SIGNATURE;
							nxt_fin  = 1'b1;
						end else begin
							nxt_phase = PH_LEN;
						end
					end else begin
						nxt_cnt = cnt_inc;
					end
				end
				PH_LEN: begin
					nxt_len = {cur_len[23:0], in_byte};
					if (cur_cnt[1:0] == 2'd3) begin
						nxt_cnt   = 32'd0;
						nxt_phase = PH_TYPE;
					end else begin
						nxt_cnt = cnt_inc;
					end
				end
				PH_TYPE: begin
					nxt_type = {cur_type[23:0], in_byte};
					if (cur_cnt[1:0] == 2'd3) begin
						nxt_cnt = 32'd0;
						if (nxt_type == pcd_pkg::TYPE_IHDR)
							nxt_seen = 1'b0;
						if (nxt_type == pcd_pkg::TYPE_IEND || cur_len == 32'd0) begin
							// end of parse: judge header and color type
							has_end = 1'b1;
							nxt_fin = 1'b1;
							if (!nxt_seen) begin
								end_kind = pcd_pkg::KIND_ERROR;
								end_err  = pcd_pkg::ERR_NO_HEADER;
							end else if (nxt_hdr[1] != req_color) begin
								end_kind = pcd_pkg::KIND_ERROR;
								end_err  = pcd_pkg::ERR_COLOR;
							end else begin
								end_kind = pcd_pkg::KIND_DONE;
								end_err  = pcd_pkg::ERR_SIGNATURE;
							end
						end else begin
							nxt_phase = PH_PAYLOAD;
						end
					end else begin
						nxt_cnt = cnt_inc;
					end
				end
				PH_PAYLOAD: begin
					if (cur_type == pcd_pkg::TYPE_IDAT)
						has_data = 1'b1;
					// header capture, bytes past the last index ignored
					if (cur_type == pcd_pkg::TYPE_IHDR && cur_cnt <= pcd_pkg::HDR_LAST_INDEX) begin
						if (cur_cnt < 32'd4)
							nxt_width = {cur_width[23:0], in_byte};
						else if (cur_cnt < 32'd8)
							nxt_height = {cur_height[23:0], in_byte};
						else
							nxt_hdr[hdr_idx] = in_byte;
						if (cur_cnt == pcd_pkg::HDR_LAST_INDEX)
							nxt_seen = 1'b1;
					end
					if (cnt_inc == cur_len) begin
						nxt_cnt   = 32'd0;
						nxt_phase = PH_CRC;
					end else begin
						nxt_cnt = cnt_inc;
					end
				end
				PH_CRC: begin
					if (cur_cnt[1:0] == 2'd3) begin
						nxt_cnt   = 32'd0;
						nxt_len   = 32'd0;
						nxt_type  = 32'd0;
						nxt_phase = PH_LEN;
					end else begin
						nxt_cnt = cnt_inc;
					end
				end
				default: begin
					nxt_phase = cur_phase;
				end
			endcase
		end
		// input ran out before the parse concluded
		if (in_final && !nxt_fin) begin
			has_end  = 1'b1;
			end_kind = pcd_pkg::KIND_ERROR;
			end_err  = pcd_pkg::ERR_TRUNCATED;
			nxt_fin  = 1'b1;
		end
	end

	// Queue entry built from the post-step header state
	assign push                = accept && (has_data || has_end);
	assign push_entry.has_data = has_data;
	assign push_entry.has_end  = has_end;
	assign push_entry.payload  = in_byte;
	assign push_entry.end_kind = end_kind;
	assign push_entry.end_err  = end_err;
	assign push_entry.width    = nxt_width;
	assign push_entry.height   = nxt_height;
	assign push_entry.hdr      = nxt_hdr;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			cnt_q    <= 32'd0;
			len_q    <= 32'd0;
			type_q   <= 32'd0;
			sig_ok_q <= 1'b1;
			width_q  <= 32'd0;
			height_q <= 32'd0;
			hdr_q    <= '0;
			seen_q   <= 1'b0;
			fin_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			cnt_q    <= nxt_cnt;
			len_q    <= nxt_len;
			type_q   <= nxt_type;
			sig_ok_q <= nxt_sig_ok;
			width_q  <= nxt_width;
			height_q <= nxt_height;
			hdr_q    <= nxt_hdr;
			seen_q   <= nxt_seen;
			fin_q    <= nxt_fin;
		end
	end

	`PCD_ASSERT_IMPLIES(a_quiet_after_end, accept && fin_q && !in_first, !push, "result after parse end")
	`PCD_ASSERT_NEXT(a_end_sets_fin, push && push_entry.has_end, fin_q, "end result left parse open")
	`PCD_ASSERT_IMPLIES(a_sig_count, phase_q == PH_SIG, cnt_q < 32'd8, "signature count overrun")

endmodule

@@ sv/pcd_queue.sv @@
// Short result queue between parser front end and output back end.
// Depends on pcd_pkg and png_chunk_deframer_unit_macros.svh.
`include "png_chunk_deframer_unit_macros.svh"

module pcd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pcd_pkg::pcd_entry_t push_entry,
	input  logic                pop,
	output pcd_pkg::pcd_entry_t head,
	output pcd_pkg::pcd_qstat_t qstat
);

	pcd_pkg::pcd_entry_t           mem_q [pcd_pkg::QUEUE_DEPTH];
	logic [pcd_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [pcd_pkg::QCNT_W-1:0]    count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == pcd_pkg::QCNT_W'(pcd_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == pcd_pkg::QPTR_W'(pcd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == pcd_pkg::QPTR_W'(pcd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`PCD_ASSERT_NEVER(a_push_full, push && qstat.full && !pop, "push into full queue")
	`PCD_ASSERT_NEVER(a_pop_empty, pop && qstat.empty, "pop from empty queue")
	`PCD_ASSERT_IMPLIES(a_count_range, 1'b1,
		count_q <= pcd_pkg::QCNT_W'(pcd_pkg::QUEUE_DEPTH), "queue count overrun")

endmodule

@@ sv/pcd_back.sv @@
// Back end of the PNG chunk deframer: expands queue entries into result items.
// Depends on pcd_pkg.
module pcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pcd_pkg::pcd_qstat_t qstat,
	input  pcd_pkg::pcd_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic [7:0]          out_payload,
	output logic [1:0]          out_err,
	output logic                out_last,
	output logic [31:0]         out_width,
	output logic [31:0]         out_height,
	output logic [4:0][7:0]     out_hdr
);

	pcd_pkg::pcd_entry_t hold_q;
	logic                data_left_q, end_left_q;
	logic                fire, last_sub, slot_free;

	assign out_valid = data_left_q || end_left_q;
	assign fire      = out_valid && out_ready;
	assign last_sub  = fire && (!data_left_q || !end_left_q);
	assign slot_free = !out_valid || last_sub;
	assign pop       = slot_free && !qstat.empty;

	// Held entry
	always_ff @(posedge clk) begin
		if (pop)
			hold_q <= head;
	end

	// Pending results of the held entry: data item first, then end item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_left_q <= 1'b0;
			end_left_q  <= 1'b0;
		end else if (pop) begin
			data_left_q <= head.has_data;
			end_left_q  <= head.has_end;
		end else if (fire) begin
			if (data_left_q)
				data_left_q <= 1'b0;
			else
				end_left_q <= 1'b0;
		end
	end

	// Result fields
	assign out_kind    = data_left_q ? pcd_pkg::KIND_DATA : hold_q.end_kind;
	assign out_payload = data_left_q ? hold_q.payload : 8'd0;
	assign out_err     = data_left_q ? pcd_pkg::ERR_SIGNATURE : hold_q.end_err;
	assign out_last    = !data_left_q;
	assign out_width   = hold_q.width;
	assign out_height  = hold_q.height;
	assign out_hdr     = hold_q.hdr;

endmodule

@@ sv/png_chunk_deframer_unit.sv @@
// PNG chunk deframer. Takes one file byte per cycle and keeps doing so as
// long as the result queue (four entries) has room. The results of an
// accepted byte pass from the parser front end into the queue and then
// into the output holding register. A byte that causes two results (the
// final data byte of a truncated file followed by its error) occupies the
// output for both results in turn; the queue absorbs that. The 8-byte
// signature, chunk length, type and CRC bytes give no results; each IDAT
// payload byte gives one data result, and the end of a file gives one
// summary or error result with tlast set. Header fields ride on every result.
// Depends on pcd_pkg, pcd_front, pcd_queue and pcd_back.
module png_chunk_deframer_unit (
	input  logic          clk,
	input  logic          arst_n,
	// input stream
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]    s_axis_tuser,   // [0] first_byte
	input  logic          s_axis_tlast,   // final_byte
	// result stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [119:0]  m_axis_tdata,   // [7:0] payload_byte, [39:8] image_width,
	                                      // [71:40] image_height, [79:72] bit_depth,
	                                      // [87:80] color_kind, [95:88] compression_method,
	                                      // [103:96] filter_method, [111:104] interlace_method,
	                                      // [113:112] error_code, [119:114] zero
	output logic [1:0]    m_axis_tuser,   // [1:0] kind
	output logic          m_axis_tlast,   // last
	// configuration port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic                req_color_q;
	logic [7:0]          req_color;
	logic                cfg_wr;
	logic                push, pop;
	pcd_pkg::pcd_entry_t push_entry, head;
	pcd_pkg::pcd_qstat_t qstat;
	logic [7:0]          out_payload;
	logic [1:0]          out_err;
	logic [31:0]         out_width, out_height;
	logic [4:0][7:0]     out_hdr;
	logic [7:0]          req_color_r;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pcd_pkg::CFG_REQ_COLOR_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_color_r <= pcd_pkg::REQ_COLOR_RESET;
			req_color_q <= 1'b0;
		end else begin
			if (cfg_wr)
				req_color_r <= pwdata[7:0];
			req_color_q <= cfg_wr;
		end
	end

	assign req_color = req_color_r;
	assign prdata = (paddr[2] == pcd_pkg::CFG_REQ_COLOR_IDX || req_color_q) &&
		(paddr[2] == pcd_pkg::CFG_REQ_COLOR_IDX) ? {24'd0, req_color_r} : 32'd0;

	pcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_first   (s_axis_tuser[0]),
		.in_final   (s_axis_tlast),
		.req_color  (req_color),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	pcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	pcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (m_axis_tuser),
		.out_payload (out_payload),
		.out_err     (out_err),
		.out_last    (m_axis_tlast),
		.out_width   (out_width),
		.out_height  (out_height),
		.out_hdr     (out_hdr)
	);

	// Result packing
	assign m_axis_tdata = {6'd0, out_err, out_hdr[4], out_hdr[3], out_hdr[2], out_hdr[1],
		out_hdr[0], out_height, out_width, out_payload};

endmodule
